/* hw/rtl/text_console_glyph_renderer_core_defines.svh */
// Assertion macros shared by the glyph renderer checker.
// No dependencies; take it in by `include before the first assertion.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_CORE_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define TCGR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define TCGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tcgr_pkg.sv */
// Types, codes and stream field layout of the text console glyph renderer.
// No dependencies; used by the core and by its checker.
package tcgr_pkg;

  // Stream widths (tdata padded to whole bytes)
  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 280;

  localparam int CHAR_W  = 8;
  localparam int FROW_W  = 3;
  localparam int PIXEL_W = 32;
  localparam int ADDR_W  = 21;

  // Input tdata layout
  localparam int IN_CHAR_LSB = 0;
  localparam int IN_FROW_LSB = 8;
  localparam int IN_BITS_LSB = 11;
  localparam int IN_FG_LSB   = 19;
  localparam int IN_BG_LSB   = 51;

  // Output tdata layout
  localparam int OUT_ADDR_LSB = 0;
  localparam int OUT_PIX_LSB  = 21;

  localparam int GLYPH_SIZE = 8;
  localparam int LINE_STEP  = 10;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;

  typedef logic [10:0]       col_t;
  typedef logic [10:0]       line_t;
  typedef logic [11:0]       cmp_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_LOAD  = 2'd2
  } action_t;

  typedef enum logic {
    KIND_ROW  = 1'b0,
    KIND_FILL = 1'b1
  } kind_t;

endpackage

/* hw/rtl/text_console_glyph_renderer_core.sv */
// Text console glyph renderer: cursor tracking, font store and row write generation.
// Depends on tcgr_pkg.
//
//  channel  | dir | tuser          | tdata (low bit first)                         | tlast
//  ---------+-----+----------------+-----------------------------------------------+------------
//  s_axis   | in  | action [1:0]   | char_code, font_row, row_bits, fg, bg, pad    | -
//  m_axis   | out | kind [0]       | start_address, pixel_0 .. pixel_7, pad        | last_of_run
//
// A drawn character is accepted, then sent as one row transaction per glyph row, after
// a fill when an automatic clear goes first; a clear action sends one fill; font loads,
// newline and carriage return send nothing, undrawable bytes only an automatic clear's fill.
// The single result channel carries one transaction per cycle while m_axis is not stalled.
// Reset: clears the cursor and the sequencer; the font store has no reset and no
// clearing pass, so a glyph must be loaded before it is drawn.
// Stalls: tready drops while a run is in progress; m_axis back-pressure holds the run.
module text_console_glyph_renderer_core #(
  parameter int SCREEN_COLUMNS = 720,
  parameter int SCREEN_ROWS    = 1600,
  parameter int GLYPH_COUNT    = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // char_code[7:0], font_row[10:8], row_bits[18:11], fg_color[50:19], bg_color[82:51]
  input  logic [tcgr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action[1:0]
  input  logic [tcgr_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // start_address[20:0], pixel_0[52:21] .. pixel_7[276:245]
  output logic [tcgr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // kind[0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int FONT_DEPTH = GLYPH_COUNT * tcgr_pkg::GLYPH_SIZE;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);

  localparam tcgr_pkg::addr_t BASE_STEP = tcgr_pkg::addr_t'(tcgr_pkg::LINE_STEP * SCREEN_COLUMNS);
  localparam tcgr_pkg::addr_t BASE_MAX  = tcgr_pkg::addr_t'(SCREEN_ROWS * SCREEN_COLUMNS);
  localparam tcgr_pkg::addr_t ROW_STEP  = tcgr_pkg::addr_t'(SCREEN_COLUMNS);

  // Input fields
  tcgr_pkg::action_t                  in_action;
  logic [tcgr_pkg::CHAR_W-1:0]        in_char;
  logic [tcgr_pkg::FROW_W-1:0]        in_frow;
  logic [7:0]                         in_bits;
  logic [tcgr_pkg::PIXEL_W-1:0]       in_fg;
  logic [tcgr_pkg::PIXEL_W-1:0]       in_bg;

  assign in_action = tcgr_pkg::action_t'(s_axis_tuser);
  assign in_char   = s_axis_tdata[tcgr_pkg::IN_CHAR_LSB +: tcgr_pkg::CHAR_W];
  assign in_frow   = s_axis_tdata[tcgr_pkg::IN_FROW_LSB +: tcgr_pkg::FROW_W];
  assign in_bits   = s_axis_tdata[tcgr_pkg::IN_BITS_LSB +: 8];
  assign in_fg     = s_axis_tdata[tcgr_pkg::IN_FG_LSB +: tcgr_pkg::PIXEL_W];
  assign in_bg     = s_axis_tdata[tcgr_pkg::IN_BG_LSB +: tcgr_pkg::PIXEL_W];

  // Cursor: column, line and the pixel index of the line's first pixel (line * width),
  // kept alongside so that no multiplier is needed.
  tcgr_pkg::col_t  col, col_next;
  tcgr_pkg::line_t line, line_next;
  tcgr_pkg::addr_t base, base_next;

  // Run sequencer
  logic                          busy;
  logic                          job_fill;
  logic                          job_draw;
  logic [2:0]                    row;
  logic [tcgr_pkg::CHAR_W-1:0]   job_code;
  logic [tcgr_pkg::PIXEL_W-1:0]  job_fg;
  logic [tcgr_pkg::PIXEL_W-1:0]  job_bg;
  tcgr_pkg::addr_t               addr;

  // Font store
  logic [7:0]          font_mem [FONT_DEPTH];
  logic [7:0]          font_q;
  logic [FONT_AW-1:0]  rd_addr;
  logic [FONT_AW-1:0]  wr_addr;
  logic                rd_en;
  logic                font_we;

  logic s_acc;
  logic out_free;
  logic emit;
  logic emit_row;
  logic start_fill;
  logic start_draw;

  // Put-character decisions
  tcgr_pkg::cmp_t  line_dn_sum;
  logic            line_sat;
  tcgr_pkg::line_t line_dn;
  tcgr_pkg::addr_t base_dn;
  logic            wrap;
  tcgr_pkg::col_t  col1, col2;
  tcgr_pkg::line_t line1, line2;
  tcgr_pkg::addr_t base1, base2;
  logic            fill_need;
  logic            draw;
  logic            code_loadable;

  logic [tcgr_pkg::OUT_DATA_W-1:0] out_data;
  tcgr_pkg::kind_t                 out_kind;
  logic                            out_last;

  assign s_axis_tready = !busy;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = busy && out_free;
  assign emit_row      = emit && !job_fill;

  // Move down one text line, saturating at the bottom of the screen
  assign line_dn_sum = {1'b0, line} + tcgr_pkg::cmp_t'(tcgr_pkg::LINE_STEP);
  assign line_sat    = line_dn_sum > tcgr_pkg::cmp_t'(SCREEN_ROWS);
  assign line_dn     = line_sat ? tcgr_pkg::line_t'(SCREEN_ROWS) : line_dn_sum[10:0];
  assign base_dn     = line_sat ? BASE_MAX : base + BASE_STEP;

  // Wrap at the right edge first, then clear if the glyph would pass the bottom
  assign wrap  = ({1'b0, col} + tcgr_pkg::cmp_t'(tcgr_pkg::GLYPH_SIZE))
                 > tcgr_pkg::cmp_t'(SCREEN_COLUMNS);
  assign col1  = wrap ? '0 : col;
  assign line1 = wrap ? line_dn : line;
  assign base1 = wrap ? base_dn : base;

  assign fill_need = ({1'b0, line1} + tcgr_pkg::cmp_t'(tcgr_pkg::GLYPH_SIZE))
                     > tcgr_pkg::cmp_t'(SCREEN_ROWS);
  assign col2  = fill_need ? '0 : col1;
  assign line2 = fill_need ? '0 : line1;
  assign base2 = fill_need ? '0 : base1;

  assign code_loadable = {1'b0, in_char} < 9'(GLYPH_COUNT);
  assign draw          = !in_char[tcgr_pkg::CHAR_W-1] && code_loadable;

  always_comb begin
    col_next   = col;
    line_next  = line;
    base_next  = base;
    start_fill = 1'b0;
    start_draw = 1'b0;
    font_we    = 1'b0;
    if (s_acc) begin
      unique case (in_action)
        tcgr_pkg::ACT_LOAD: begin
          font_we = code_loadable;
        end
        tcgr_pkg::ACT_CLEAR: begin
          col_next   = '0;
          line_next  = '0;
          base_next  = '0;
          start_fill = 1'b1;
        end
        tcgr_pkg::ACT_PUT: begin
          unique case (in_char)
            tcgr_pkg::CHAR_NEWLINE: begin
              col_next  = '0;
              line_next = line_dn;
              base_next = base_dn;
            end
            tcgr_pkg::CHAR_CR: begin
              col_next = '0;
            end
            default: begin
              // Undrawable bytes still take the wrap and the clear
              col_next   = draw ? col2 + tcgr_pkg::col_t'(tcgr_pkg::GLYPH_SIZE) : col2;
              line_next  = line2;
              base_next  = base2;
              start_fill = fill_need;
              start_draw = draw;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Font reads: row 0 on acceptance, then the next row each time a row leaves, so the
  // registered row is ready whenever the output register frees up. Writes happen only
  // on acceptance while idle; a read meets a write to the same entry only on a load, whose read goes unused.
  assign rd_en   = s_acc || emit_row;
  assign rd_addr = s_acc ? FONT_AW'({in_char, 3'd0}) : FONT_AW'({job_code, row + 3'd1});
  assign wr_addr = FONT_AW'({in_char, in_frow});

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[wr_addr] <= in_bits;
    end
    if (rd_en) begin
      font_q <= font_mem[rd_addr];
    end
  end

  // Result assembly: a fill carries only the colour, a row write maps bit 7 to column 0
  always_comb begin
    out_data = '0;
    out_kind = tcgr_pkg::KIND_ROW;
    out_last = (row == 3'd7);
    if (job_fill) begin
      out_kind = tcgr_pkg::KIND_FILL;
      out_last = !job_draw;
      out_data[tcgr_pkg::OUT_PIX_LSB +: tcgr_pkg::PIXEL_W] = job_bg;
    end else begin
      out_data[tcgr_pkg::OUT_ADDR_LSB +: tcgr_pkg::ADDR_W] = addr;
      for (int i = 0; i < tcgr_pkg::GLYPH_SIZE; i++) begin
        out_data[tcgr_pkg::OUT_PIX_LSB + i * tcgr_pkg::PIXEL_W +: tcgr_pkg::PIXEL_W] =
          font_q[tcgr_pkg::GLYPH_SIZE - 1 - i] ? job_fg : job_bg;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      job_code <= in_char;
      job_fg   <= in_fg;
      job_bg   <= in_bg;
      addr     <= base2 + tcgr_pkg::addr_t'(col2);
    end else if (emit_row) begin
      addr <= addr + ROW_STEP;
    end
    if (emit) begin
      m_axis_tdata <= out_data;
      m_axis_tuser <= out_kind;
      m_axis_tlast <= out_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      line          <= '0;
      base          <= '0;
      busy          <= 1'b0;
      job_fill      <= 1'b0;
      job_draw      <= 1'b0;
      row           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      col  <= col_next;
      line <= line_next;
      base <= base_next;
      if (s_acc) begin
        busy     <= start_fill || start_draw;
        job_fill <= start_fill;
        job_draw <= start_draw;
        row      <= '0;
      end else if (emit) begin
        if (job_fill) begin
          // Fill goes first; carry on with the glyph if there is one
          job_fill <= 1'b0;
          busy     <= job_draw;
        end else begin
          row <= row + 3'd1;
          if (row == 3'd7) begin
            busy <= 1'b0;
          end
        end
      end
      if (out_free) begin
        m_axis_tvalid <= emit;
      end
    end
  end

endmodule

/* hw/rtl/tcgr_checker.sv */
// Port-level checker for the glyph renderer core, bound to the core module.
// Depends on tcgr_pkg and text_console_glyph_renderer_core_defines.svh.
`include "text_console_glyph_renderer_core_defines.svh"

module tcgr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [tcgr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic [tcgr_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tcgr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tlast
);

  // Hold a stalled result unchanged
  `TCGR_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // A fill always addresses pixel zero
  `TCGR_ASSERT_SAME(a_fill_addr, clk, rst, m_axis_tvalid && m_axis_tuser == tcgr_pkg::KIND_FILL, m_axis_tdata[tcgr_pkg::OUT_ADDR_LSB +: tcgr_pkg::ADDR_W] == '0, "fill with nonzero address")

  // A run streams without gaps once its first result is out
  `TCGR_ASSERT_NEXT(a_run_gapless, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a run")

  // No new transaction is taken while a run is still unfinished
  `TCGR_ASSERT_SAME(a_run_blocks_input, clk, rst, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input taken during a run")

endmodule

bind text_console_glyph_renderer_core tcgr_checker u_tcgr_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for text_console_glyph_renderer_core: sends put, clear and font-load
// transactions, predicts every pixel command the core should emit and checks them in order.
// Depends on tcgr_pkg and the core RTL; needs no files or arguments.
module tb_top;
  import tcgr_pkg::*;

  localparam int COLS         = 720;
  localparam int ROWS         = 1600;
  localparam int GLYPHS       = 128;
  localparam int CLK_HALF     = 6;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 470;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int MIX_PERIOD   = 40;

  // One pixel command as it leaves the core
  typedef struct packed {
    kind_t                   kind;
    addr_t                   addr;
    logic [7:0][PIXEL_W-1:0] pix;
    logic                    last;
  } pixel_cmd_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = ACT_PUT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  // Shadow of the core's cursor and font store
  int unsigned shadow_col  = 0;
  int unsigned shadow_line = 0;
  logic [7:0]  shadow_font [GLYPHS*8];
  pixel_cmd_t  expected_cmds[$];

  // Stimulus bookkeeping: only glyphs with all eight rows loaded may be drawn
  logic [7:0] rows_loaded [GLYPHS] = '{default: '0};
  logic [7:0] ready_glyphs[$];

  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int hold_left   = 0;
  int fail_count  = 0;

  text_console_glyph_renderer_core #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS   (ROWS),
    .GLYPH_COUNT   (GLYPHS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------
  function automatic void push_fill(logic [31:0] colour);
    pixel_cmd_t cmd;
    cmd = '0;
    cmd.kind = KIND_FILL;
    cmd.pix[0] = colour;
    expected_cmds.push_back(cmd);
  endfunction

  // Move down one text line, never past the bottom edge
  function automatic void cursor_line_down();
    shadow_line = (shadow_line + LINE_STEP > ROWS) ? ROWS : shadow_line + LINE_STEP;
  endfunction

  function automatic void predict_render(action_t act, logic [7:0] ch, logic [2:0] frow,
                                         logic [7:0] bits, logic [31:0] fg,
                                         logic [31:0] bg);
    pixel_cmd_t  cmd;
    int          n_before;
    int unsigned code;
    logic [7:0]  pattern;
    n_before = expected_cmds.size();
    code = ch;
    case (act)
      ACT_LOAD: begin
        if (code < GLYPHS) shadow_font[code*8 + frow] = bits;
      end
      ACT_CLEAR: begin
        push_fill(bg);
        shadow_col  = 0;
        shadow_line = 0;
      end
      ACT_PUT: begin
        if (ch == CHAR_NEWLINE) begin
          shadow_col = 0;
          cursor_line_down();
        end else if (ch == CHAR_CR) begin
          shadow_col = 0;
        end else begin
          // wrap first, then clear if the glyph would run off the bottom
          if (shadow_col + GLYPH_SIZE > COLS) begin
            shadow_col = 0;
            cursor_line_down();
          end
          if (shadow_line + GLYPH_SIZE > ROWS) begin
            push_fill(bg);
            shadow_col  = 0;
            shadow_line = 0;
          end
          if (code < GLYPHS) begin
            for (int r = 0; r < GLYPH_SIZE; r++) begin
              cmd = '0;
              cmd.kind = KIND_ROW;
              cmd.addr = addr_t'((shadow_line + r) * COLS + shadow_col);
              pattern = shadow_font[code*8 + r];
              for (int c = 0; c < 8; c++) cmd.pix[c] = pattern[7-c] ? fg : bg;
              expected_cmds.push_back(cmd);
            end
            shadow_col += GLYPH_SIZE;
          end
        end
      end
      default: ;
    endcase
    // flag the final command of this run
    if (expected_cmds.size() > n_before) begin
      cmd = expected_cmds.pop_back();
      cmd.last = 1'b1;
      expected_cmds.push_back(cmd);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------------------
  // Offer one transaction and return at the edge that accepts it. Valid stays high so that
  // a following call can present the next item without a bubble.
  task automatic send_item(action_t act, logic [7:0] ch, logic [2:0] frow, logic [7:0] bits,
                           logic [31:0] fg, logic [31:0] bg);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'b0, bg, fg, bits, frow, ch};
    do @(posedge clk); while (!s_axis_tready);
    predict_render(act, ch, frow, bits, fg, bg);
  endtask

  task automatic put_char(logic [7:0] ch);
    send_item(ACT_PUT, ch, 3'($urandom), 8'($urandom), $urandom, $urandom);
  endtask

  task automatic clear_screen(logic [31:0] bg);
    send_item(ACT_CLEAR, 8'($urandom), 3'($urandom), 8'($urandom), $urandom, bg);
  endtask

  task automatic load_row(logic [7:0] code, logic [2:0] frow, logic [7:0] bits);
    bit was_ready;
    send_item(ACT_LOAD, code, frow, bits, $urandom, $urandom);
    if (code < GLYPHS) begin
      was_ready = &rows_loaded[code];
      rows_loaded[code][frow] = 1'b1;
      if (!was_ready && &rows_loaded[code]) ready_glyphs.push_back(code);
    end
  endtask

  // Row r of the glyph comes from rows[8*r +: 8]
  task automatic load_glyph(logic [7:0] code, logic [63:0] rows);
    for (int r = 0; r < GLYPH_SIZE; r++) load_row(code, 3'(r), rows[8*r +: 8]);
  endtask

  function automatic logic [7:0] pick_glyph();
    return ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
  endfunction

  // Drop valid and hold until every predicted command has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_cmds.size() != 0);
  endtask

  // ---------------------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------------------
  function automatic void check_field(string what, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, seen);
      fail_count++;
    end
  endfunction

  // Accept results with a per-transaction random stall, plus the long hold when asked.
  // Compare on the falling edge so the prediction for a same-edge acceptance is in place.
  initial begin : result_sink
    pixel_cmd_t seen;
    pixel_cmd_t want;
    bit         hit;
    int         stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      hit = !rst && m_axis_tvalid && m_axis_tready;
      if (hit) begin
        seen.kind = kind_t'(m_axis_tuser);
        seen.addr = m_axis_tdata[OUT_ADDR_LSB +: ADDR_W];
        for (int i = 0; i < 8; i++)
          seen.pix[i] = m_axis_tdata[OUT_PIX_LSB + i*PIXEL_W +: PIXEL_W];
        seen.last = m_axis_tlast;
        stall_left = snk_idle_en ? $urandom_range(0, 14) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_left > 0) hold_left--;
      m_axis_tready <= !rst && stall_left == 0 && hold_left == 0;
      if (hit) begin
        @(negedge clk);
        if (expected_cmds.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected result, address %h", $time, seen.addr);
          fail_count++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("kind", 32'(want.kind), 32'(seen.kind));
          check_field("start_address", 32'(want.addr), 32'(seen.addr));
          for (int i = 0; i < 8; i++)
            check_field($sformatf("pixel_%0d", i), want.pix[i], seen.pix[i]);
          check_field("last_of_run", 32'(want.last), 32'(seen.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------
  // Colour extremes, both clear colours, undrawable bytes, newline, carriage return and
  // font loads past the end of the font
  task automatic test_basic_ops();
    clear_screen(32'h0000_0000);
    clear_screen(32'hFFFF_FFFF);
    load_glyph(8'h00, 64'h0FF0_55AA_0180_00FF);
    load_glyph(8'h7F, ~64'h0FF0_55AA_0180_00FF);
    // out-of-range glyph numbers are dropped and must not alias onto real rows
    load_row(8'h80, 3'd7, 8'hA5);
    load_row(8'hFF, 3'd0, 8'h3C);
    send_item(ACT_PUT, 8'h00, 3'd0, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(ACT_PUT, 8'h7F, 3'd7, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
    put_char(8'h80);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(CHAR_NEWLINE);
    put_char(8'h7F);
    put_char(CHAR_CR);
    put_char(8'h00);
    drain();
  endtask

  // Fill a line to the right edge, then wrap once on an undrawable byte and once on a glyph
  task automatic test_right_wrap();
    clear_screen($urandom);
    repeat (COLS / GLYPH_SIZE) put_char(pick_glyph());
    put_char(8'h80);
    repeat (COLS / GLYPH_SIZE) put_char(pick_glyph());
    put_char(pick_glyph());
    drain();
  endtask

  // Bottom edge: last line that fits, wrap into an automatic clear, line saturation,
  // and an automatic clear ahead of a byte that draws nothing
  task automatic test_bottom_edge();
    clear_screen($urandom);
    repeat (ROWS / LINE_STEP - 1) put_char(CHAR_NEWLINE);
    repeat (COLS / GLYPH_SIZE) put_char(pick_glyph());
    put_char(pick_glyph());
    repeat (ROWS / LINE_STEP + 40) put_char(CHAR_NEWLINE);
    put_char(8'hFF);
    repeat (ROWS / LINE_STEP + 40) put_char(CHAR_NEWLINE);
    put_char(CHAR_CR);
    put_char(pick_glyph());
    drain();
  endtask

  // Hold the result side off for a long stretch while the sender keeps offering glyphs
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    hold_left   = HOLD_CYCLES;
    repeat (12) put_char(pick_glyph());
    drain();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  // Mostly whole-glyph loads and drawing, with stray rows, control bytes, clears and runs
  // of newlines that carry the cursor towards the bottom edge
  task automatic test_random_traffic();
    int sent;
    int next_mix;
    int choice;
    int burst;
    sent     = 0;
    next_mix = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_mix) begin
        src_idle_en = $urandom_range(0, 2) != 0;
        snk_idle_en = $urandom_range(0, 2) != 0;
        next_mix    = sent + MIX_PERIOD;
      end
      choice = $urandom_range(0, 99);
      if (choice < 10) begin
        load_glyph(8'($urandom_range(0, GLYPHS - 1)), {$urandom, $urandom});
        sent += GLYPH_SIZE;
      end else if (choice < 15) begin
        load_row(8'($urandom), 3'($urandom), 8'($urandom));
        sent++;
      end else if (choice < 55) begin
        put_char(pick_glyph());
        sent++;
      end else if (choice < 61) begin
        put_char(8'($urandom_range(128, 255)));
        sent++;
      end else if (choice < 69) begin
        put_char(CHAR_NEWLINE);
        sent++;
      end else if (choice < 73) begin
        put_char(CHAR_CR);
        sent++;
      end else if (choice < 76) begin
        clear_screen($urandom);
        sent++;
      end else if (choice < 81) begin
        burst = $urandom_range(10, 60);
        repeat (burst) put_char(CHAR_NEWLINE);
        sent += burst;
      end else begin
        burst = $urandom_range(5, 40);
        repeat (burst) put_char(pick_glyph());
        sent += burst;
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence and run limit
  // ---------------------------------------------------------------------------------------
  initial begin : main_sequence
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_right_wrap();
    test_bottom_edge();
    test_backpressure();
    test_random_traffic();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

endmodule
